[hw/rtl/htil_pkg.sv]
package htil_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned OUT_ADDR_W  = 20;
  localparam int unsigned DCOUNT_W    = 3;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [CHAR_W-1:0] CHAR_AT    = 8'h40;
  localparam logic [CHAR_W-1:0] CHAR_Q     = 8'h71;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;

  localparam logic [DCOUNT_W-1:0] DCOUNT_MIN   = 3'd4;
  localparam logic [DCOUNT_W-1:0] DCOUNT_MAX   = 3'd5;
  localparam logic [DCOUNT_W-1:0] DCOUNT_RESET = 3'd4;
  localparam logic [CHAR_W-1:0]   THRESH_RESET = 8'd32;

  localparam logic REG_DIGIT_COUNT = 1'b0;
  localparam logic REG_THRESHOLD   = 1'b1;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] write_address;
    logic [CHAR_W-1:0]     write_byte;
    logic                  image_end;
  } result_t;

  function automatic logic [3:0] addr_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    begin
      v = 8'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        v = c - CHAR_ZERO;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
        v = c - CHAR_UA + 8'd10;
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
        v = c - CHAR_LA + 8'd10;
      end
      return v[3:0];
    end
  endfunction

  function automatic logic [CHAR_W-1:0] data_digit(input logic [CHAR_W-1:0] c);
    begin
      if (c > CHAR_NINE) begin
        return c - CHAR_UA + 8'd10;
      end
      return c - CHAR_ZERO;
    end
  endfunction

endpackage

[hw/rtl/htil_decode.sv]
module htil_decode #(
  parameter int unsigned ADDRESS_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [htil_pkg::CHAR_W-1:0]   ch,
  input  logic [htil_pkg::DCOUNT_W-1:0] digit_count,
  input  logic [htil_pkg::CHAR_W-1:0]   threshold,
  output logic                          res_valid,
  output htil_pkg::result_t             res,
  output logic                          finished
);

  logic                          collecting_address, collecting_address_next;
  logic [htil_pkg::DCOUNT_W-1:0] digit_counter, digit_counter_next;
  logic [ADDRESS_WIDTH-1:0]      address_accumulator, address_accumulator_next;
  logic [ADDRESS_WIDTH-1:0]      base_address, base_address_next;
  logic [ADDRESS_WIDTH-1:0]      write_offset, write_offset_next;
  logic [htil_pkg::CHAR_W-1:0]   high_digit_held, high_digit_held_next;
  logic                          second_digit_phase, second_digit_phase_next;
  logic                          finished_next;

  logic [htil_pkg::DCOUNT_W-1:0] need;
  logic                          data_path;
  logic [ADDRESS_WIDTH-1:0]      base_eff;
  logic [ADDRESS_WIDTH-1:0]      sum;
  logic [ADDRESS_WIDTH+htil_pkg::OUT_ADDR_W-1:0] sum_ext;
  logic [htil_pkg::CHAR_W-1:0]   hn, ln;

  always_comb begin
    priority if (digit_count < htil_pkg::DCOUNT_MIN) begin
      need = htil_pkg::DCOUNT_MIN;
    end else if (digit_count > htil_pkg::DCOUNT_MAX) begin
      need = htil_pkg::DCOUNT_MAX;
    end else begin
      need = digit_count;
    end
  end

  assign hn      = htil_pkg::data_digit(high_digit_held);
  assign ln      = htil_pkg::data_digit(ch);
  assign sum     = base_eff + write_offset;
  assign sum_ext = {{htil_pkg::OUT_ADDR_W{1'b0}}, sum};

  always_comb begin
    collecting_address_next  = collecting_address;
    digit_counter_next       = digit_counter;
    address_accumulator_next = address_accumulator;
    base_address_next        = base_address;
    write_offset_next        = write_offset;
    high_digit_held_next     = high_digit_held;
    second_digit_phase_next  = second_digit_phase;
    finished_next            = finished;
    res_valid                = 1'b0;
    res                      = '0;
    data_path                = 1'b0;
    base_eff                 = base_address;

    priority if (finished) begin
      data_path = 1'b0;
    end else if (ch == htil_pkg::CHAR_Q) begin
      finished_next = 1'b1;
      res_valid     = 1'b1;
      res.image_end = 1'b1;
    end else if (ch <= threshold) begin
      data_path = 1'b0;
    end else if (ch == htil_pkg::CHAR_AT) begin
      collecting_address_next  = 1'b1;
      digit_counter_next       = '0;
      address_accumulator_next = '0;
      base_address_next        = '0;
      write_offset_next        = '0;
    end else if (collecting_address && digit_counter < need) begin
      address_accumulator_next = {address_accumulator[ADDRESS_WIDTH-5:0],
                                  htil_pkg::addr_digit(ch)};
      digit_counter_next       = digit_counter + 3'd1;
    end else begin
      data_path = 1'b1;
      if (collecting_address) begin
        collecting_address_next = 1'b0;
        base_address_next       = address_accumulator;
        digit_counter_next      = '0;
        base_eff                = address_accumulator;
      end
    end

    if (data_path) begin
      if (!second_digit_phase) begin
        high_digit_held_next    = ch;
        second_digit_phase_next = 1'b1;
      end else begin
        second_digit_phase_next = 1'b0;
        high_digit_held_next    = '0;
        write_offset_next       = write_offset + {{(ADDRESS_WIDTH-1){1'b0}}, 1'b1};
        res_valid               = 1'b1;
        res.write_address       = sum_ext[htil_pkg::OUT_ADDR_W-1:0];
        res.write_byte          = {hn[3:0], 4'b0000} | ln;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting_address  <= 1'b0;
      digit_counter       <= '0;
      address_accumulator <= '0;
      base_address        <= '0;
      write_offset        <= '0;
      high_digit_held     <= '0;
      second_digit_phase  <= 1'b0;
      finished            <= 1'b0;
    end else if (step) begin
      collecting_address  <= collecting_address_next;
      digit_counter       <= digit_counter_next;
      address_accumulator <= address_accumulator_next;
      base_address        <= base_address_next;
      write_offset        <= write_offset_next;
      high_digit_held     <= high_digit_held_next;
      second_digit_phase  <= second_digit_phase_next;
      finished            <= finished_next;
    end
  end

endmodule

[hw/rtl/htil_out_reg.sv]
module htil_out_reg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  htil_pkg::result_t                   res,
  input  logic                                out_stall,
  output logic                                out_free,
  output logic                                out_valid,
  output logic [htil_pkg::OUT_ADDR_W-1:0]     write_address,
  output logic [htil_pkg::CHAR_W-1:0]         write_byte,
  output logic                                image_end
);

  htil_pkg::result_t hold;

  assign out_free      = !out_valid || !out_stall;
  assign write_address = hold.write_address;
  assign write_byte    = hold.write_byte;
  assign image_end     = hold.image_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      hold <= res;
    end
  end

endmodule

[hw/rtl/hex_text_image_loader.sv]
// Characters go through the input register, then the output register.
// Throughput: one character per cycle while not stalled; input and output
//   registers hold one each; an output stall backs up once a result is due.
// Reset (rst, synchronous): clears decode state to data mode, offset and base
//   to zero; digit count returns to 4 and control threshold to 32.
module hex_text_image_loader #(
  parameter int unsigned ADDRESS_WIDTH = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [htil_pkg::CHAR_W-1:0]         text_char,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [htil_pkg::OUT_ADDR_W-1:0]     write_address,
  output logic [htil_pkg::CHAR_W-1:0]         write_byte,
  output logic                                image_end,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [htil_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [htil_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [htil_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic [htil_pkg::DCOUNT_W-1:0] digit_count;
  logic [htil_pkg::CHAR_W-1:0]   threshold;
  logic                          s1_valid;
  logic [htil_pkg::CHAR_W-1:0]   s1_char;
  logic                          step;
  logic                          res_valid;
  htil_pkg::result_t             res;
  logic                          finished;
  logic                          out_free;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == htil_pkg::REG_THRESHOLD) ?
                  {{(htil_pkg::APB_DATA_W-htil_pkg::CHAR_W){1'b0}}, threshold} :
                  {{(htil_pkg::APB_DATA_W-htil_pkg::DCOUNT_W){1'b0}}, digit_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= htil_pkg::DCOUNT_RESET;
      threshold   <= htil_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == htil_pkg::REG_THRESHOLD) begin
        threshold <= pwdata[htil_pkg::CHAR_W-1:0];
      end else begin
        digit_count <= pwdata[htil_pkg::DCOUNT_W-1:0];
      end
    end
  end

  // advance a beat unless it makes a result and the output is blocked
  assign step     = s1_valid && (!res_valid || out_free);
  assign in_stall = s1_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_char <= text_char;
    end
  end

  htil_decode #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .ch          (s1_char),
    .digit_count (digit_count),
    .threshold   (threshold),
    .res_valid   (res_valid),
    .res         (res),
    .finished    (finished)
  );

  htil_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step && res_valid),
    .res           (res),
    .out_stall     (out_stall),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .write_address (write_address),
    .write_byte    (write_byte),
    .image_end     (image_end)
  );

  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_end |-> write_address == '0 && write_byte == '0)
    else $error("end beat carries address or data");

  a_finished_sticks: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished flag dropped without reset");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    step && res_valid |=> out_valid)
    else $error("result lost on the way to the output register");

endmodule
